// ----- sv/rme_pkg.sv -----
// Shared types, constants and fixed-point helpers for rotation_matrix_to_euler.
// Used by rme_isqrt, rme_cordic and the top level; no dependencies.
package rme_pkg;

  // CORDIC datapath width: Q28 operands with gain headroom, angles up to 3pi/2
  localparam int CD_W     = 34;
  localparam int CD_PER   = 2;    // CORDIC iterations per pipeline stage
  localparam int TAB_LEN  = 24;

  // Restoring square root of a 57-bit operand, 29 result bits
  localparam int SQRT_STEPS = 29;
  localparam int SQRT_PER   = 4;
  localparam int SQRT_W     = 58;
  localparam int SQRT_ST    = (SQRT_STEPS + SQRT_PER - 1) / SQRT_PER;

  typedef logic signed [CD_W-1:0] cd_t;

  localparam cd_t PI_Q30      = 34'sd3373259426;
  localparam cd_t HALF_PI_Q30 = 34'sd1686629713;

  typedef enum logic [1:0] {
    CASE_GEN1   = 2'd0,
    CASE_GEN2   = 2'd1,
    CASE_LOCK_M = 2'd2,
    CASE_LOCK_P = 2'd3
  } case_t;

  // Item side data carried alongside the square-root stages
  typedef struct packed {
    logic signed [16:0] zy;
    logic signed [16:0] zx;
    logic signed [15:0] m23;
    logic signed [15:0] m33;
    logic signed [15:0] s;
    logic               lkm;
    logic               lkp;
  } side_t;

  // atan(2^-i) in Q30
  function automatic cd_t atan_tab(input logic [4:0] i);
    cd_t v;
    unique case (i)
      5'd0:  v = 34'sh03243F6A8;
      5'd1:  v = 34'sh01DAC6705;
      5'd2:  v = 34'sh00FADBAFC;
      5'd3:  v = 34'sh007F56EA6;
      5'd4:  v = 34'sh003FEAB76;
      5'd5:  v = 34'sh001FFD55B;
      5'd6:  v = 34'sh000FFFAAA;
      5'd7:  v = 34'sh0007FFF55;
      5'd8:  v = 34'sh0003FFFEA;
      5'd9:  v = 34'sh0001FFFFD;
      5'd10: v = 34'sh0000FFFFF;
      5'd11: v = 34'sh00007FFFF;
      5'd12: v = 34'sh00003FFFF;
      5'd13: v = 34'sh00001FFFF;
      5'd14: v = 34'sh00000FFFF;
      5'd15: v = 34'sh000007FFF;
      5'd16: v = 34'sh000003FFF;
      5'd17: v = 34'sh000001FFF;
      5'd18: v = 34'sh000000FFF;
      5'd19: v = 34'sh0000007FF;
      5'd20: v = 34'sh0000003FF;
      5'd21: v = 34'sh0000001FF;
      5'd22: v = 34'sh0000000FF;
      5'd23: v = 34'sh00000007F;
      default: v = '0;
    endcase
    return v;
  endfunction

  // Q2.14 value (17-bit signed) to Q28 CORDIC operand
  function automatic cd_t to_q30(input logic signed [16:0] v);
    return {{(CD_W-31){v[16]}}, v, 14'b0};
  endfunction

  // Q30 to Q4.12, round half away from zero, saturate
  function automatic logic signed [15:0] to_q12(input cd_t v);
    logic [CD_W-1:0] m;
    logic [CD_W-1:0] r;
    logic signed [15:0] res;
    m = v[CD_W-1] ? CD_W'(-v) : CD_W'(v);
    r = (m + CD_W'(1 << 17)) >> 18;
    if (v[CD_W-1]) begin
      if (r > CD_W'(32768)) res = -16'sd32768;
      else res = -$signed(r[15:0]);
    end else begin
      if (r > CD_W'(32767)) res = 16'sd32767;
      else res = $signed(r[15:0]);
    end
    return res;
  endfunction

endpackage

// ----- sv/rme_isqrt.sv -----
// Pipelined restoring integer square root, SQRT_PER bits per stage.
// Depends on rme_pkg; stage enables come from the top-level flow control.
module rme_isqrt (
  input  logic                            clk,
  input  logic [rme_pkg::SQRT_ST-1:0]     en,
  input  logic [56:0]                     n_i,
  output logic [28:0]                     root_o
);

  localparam int NST = rme_pkg::SQRT_ST;
  localparam int W   = rme_pkg::SQRT_W;

  logic [W-1:0] n_r [NST];
  logic [W-1:0] r_r [NST];

  genvar j;
  generate
    for (j = 0; j < NST; j++) begin : g_st
      logic [W-1:0] n_nxt;
      logic [W-1:0] r_nxt;

      // SQRT_PER result bits per stage
      always_comb begin
        logic [W-1:0] b;
        logic [W-1:0] rb;
        if (j == 0) begin
          n_nxt = {1'b0, n_i};
          r_nxt = '0;
        end else begin
          n_nxt = n_r[(j == 0) ? 0 : j-1];
          r_nxt = r_r[(j == 0) ? 0 : j-1];
        end
        for (int k = 0; k < rme_pkg::SQRT_PER; k++) begin
          if (j*rme_pkg::SQRT_PER + k < rme_pkg::SQRT_STEPS) begin
            b  = W'(1) << (2*(rme_pkg::SQRT_STEPS - 1 - (j*rme_pkg::SQRT_PER + k)));
            rb = r_nxt + b;
            if (n_nxt >= rb) begin
              n_nxt = n_nxt - rb;
              r_nxt = (r_nxt >> 1) + b;
            end else begin
              r_nxt = r_nxt >> 1;
            end
          end
        end
      end

      always_ff @(posedge clk) begin
        if (en[j]) begin
          n_r[j] <= n_nxt;
          r_r[j] <= r_nxt;
        end
      end
    end
  endgenerate

  assign root_o = r_r[NST-1][28:0];

endmodule

// ----- sv/rme_cordic.sv -----
// Pipelined vectoring CORDIC atan2 with Q30 angle accumulator.
// Depends on rme_pkg; stage enables come from the top-level flow control.
module rme_cordic #(
  parameter int STEPS = 14
) (
  input  logic                                              clk,
  input  logic [(STEPS+rme_pkg::CD_PER-1)/rme_pkg::CD_PER-1:0] en,
  input  rme_pkg::cd_t                                      y_i,
  input  rme_pkg::cd_t                                      x_i,
  output rme_pkg::cd_t                                      ang_o
);

  localparam int NST = (STEPS + rme_pkg::CD_PER - 1) / rme_pkg::CD_PER;

  rme_pkg::cd_t x_r [NST];
  rme_pkg::cd_t y_r [NST];
  rme_pkg::cd_t a_r [NST];
  logic         z_r [NST];

  genvar j;
  generate
    for (j = 0; j < NST; j++) begin : g_st
      rme_pkg::cd_t x_nxt, y_nxt, a_nxt;
      logic         z_nxt;

      always_comb begin
        rme_pkg::cd_t nx, ny;
        int i;
        if (j == 0) begin
          // zero vector flag and half-plane pre-rotation
          z_nxt = (x_i == '0) && (y_i == '0);
          if (x_i[rme_pkg::CD_W-1]) begin
            a_nxt = y_i[rme_pkg::CD_W-1] ? -rme_pkg::PI_Q30 : rme_pkg::PI_Q30;
            x_nxt = -x_i;
            y_nxt = -y_i;
          end else begin
            a_nxt = '0;
            x_nxt = x_i;
            y_nxt = y_i;
          end
        end else begin
          z_nxt = z_r[(j == 0) ? 0 : j-1];
          a_nxt = a_r[(j == 0) ? 0 : j-1];
          x_nxt = x_r[(j == 0) ? 0 : j-1];
          y_nxt = y_r[(j == 0) ? 0 : j-1];
        end
        for (int k = 0; k < rme_pkg::CD_PER; k++) begin
          i = j*rme_pkg::CD_PER + k;
          if (i < STEPS && i < rme_pkg::TAB_LEN) begin
            if (!y_nxt[rme_pkg::CD_W-1]) begin
              nx    = x_nxt + (y_nxt >>> i);
              ny    = y_nxt - (x_nxt >>> i);
              a_nxt = a_nxt + rme_pkg::atan_tab(5'(i));
            end else begin
              nx    = x_nxt - (y_nxt >>> i);
              ny    = y_nxt + (x_nxt >>> i);
              a_nxt = a_nxt - rme_pkg::atan_tab(5'(i));
            end
            x_nxt = nx;
            y_nxt = ny;
          end
        end
      end

      always_ff @(posedge clk) begin
        if (en[j]) begin
          x_r[j] <= x_nxt;
          y_r[j] <= y_nxt;
          a_r[j] <= a_nxt;
          z_r[j] <= z_nxt;
        end
      end
    end
  endgenerate

  assign ang_o = z_r[NST-1] ? '0 : a_r[NST-1];

endmodule

// ----- sv/rotation_matrix_to_euler.sv -----
// Top level: rotation matrix entries to Euler angles, fully pipelined.
// Depends on rme_pkg, rme_isqrt and rme_cordic.
//
// Usage:
//  in_*  : one matrix item (m11, m12, m13, m21, m23, m31, m33, Q2.14) per
//          handshake; accepted when in_tvalid and in_tready are both high.
//  out_* : angle_x, angle_y, angle_z (Q4.12 radians) in out_tdata and the
//          solution case in out_tuser.
//  cfg_* : cfg_we writes gimbal_tolerance from cfg_wdata at the clock edge;
//          write it only while the pipeline is empty.
// Stages, in order: input register, multiply, 8 square-root stages (4 root
// bits each, 1 in the last), CORDIC stages (2 iterations each, 5 units in
// parallel), rounding, select. Throughput is one item per cycle while
// out_tready is high. Each stage holds a valid bit; a stage takes new data
// when it is empty or its successor moves, so a stalled receiver fills the
// bubbles first and then holds in_tready low; nothing is lost or repeated.
// Reset (rst_n low, synchronous) empties the pipeline and sets
// gimbal_tolerance to 1.
module rotation_matrix_to_euler #(
  parameter int CORDIC_STEPS = 14
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic [9:0]   cfg_wdata,
  input  logic         in_tvalid,
  output logic         in_tready,
  // m11, m12, m13, m21, m23, m31, m33 (16 bits each, from bit 0 up)
  input  logic [111:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // angle_x, angle_y, angle_z (16 bits each, from bit 0 up)
  output logic [47:0]  out_tdata,
  // solution_case (2 bits)
  output logic [1:0]   out_tuser
);

  localparam int SQ_ST = rme_pkg::SQRT_ST;
  localparam int CD_ST = (CORDIC_STEPS + rme_pkg::CD_PER - 1) / rme_pkg::CD_PER;
  localparam int SB    = 2;
  localparam int CB    = SB + SQ_ST;
  localparam int RI    = CB + CD_ST;
  localparam int OI    = RI + 1;
  localparam int NSTG  = OI + 1;

  // Configuration register
  logic [9:0] tol_r;
  always_ff @(posedge clk) begin
    if (!rst_n) tol_r <= 10'd1;
    else if (cfg_we) tol_r <= cfg_wdata;
  end

  // Stage flow control
  logic [NSTG-1:0] v_r;
  logic [NSTG:0]   adv;

  assign adv[NSTG] = out_tready;
  genvar k;
  generate
    for (k = 0; k < NSTG; k++) begin : g_adv
      assign adv[k] = !v_r[k] || adv[k+1];
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int s = 0; s < NSTG; s++) begin
        if (adv[s]) v_r[s] <= (s == 0) ? in_tvalid : v_r[(s == 0) ? 0 : s-1];
      end
    end
  end

  assign in_tready = adv[0];

  // Stage 0: register item, saturate m13, detect gimbal lock
  logic signed [15:0] m11_r, m12_r, m21_r, m23_r, m31_r, m33_r, s0_r;
  logic               lkm0_r, lkp0_r;
  logic signed [15:0] m13_in, m13_sat;
  logic [15:0]        dist_m, dist_p;

  assign m13_in  = $signed(in_tdata[47:32]);
  assign m13_sat = (m13_in > 16'sd16384)  ? 16'sd16384 :
                   (m13_in < -16'sd16384) ? -16'sd16384 : m13_in;
  assign dist_m  = 16'(m13_sat + 16'sd16384);
  assign dist_p  = 16'(16'sd16384 - m13_sat);

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      m11_r  <= $signed(in_tdata[15:0]);
      m12_r  <= $signed(in_tdata[31:16]);
      m21_r  <= $signed(in_tdata[63:48]);
      m23_r  <= $signed(in_tdata[79:64]);
      m31_r  <= $signed(in_tdata[95:80]);
      m33_r  <= $signed(in_tdata[111:96]);
      s0_r   <= m13_sat;
      lkm0_r <= dist_m < {6'd0, tol_r};
      lkp0_r <= dist_p < {6'd0, tol_r};
    end
  end

  // Stage 1: 1 - s^2 for the square root, choose z operands
  logic [56:0]   n1_r;
  rme_pkg::side_t sd1_r;
  logic [31:0]   sq;

  assign sq = 32'($signed(s0_r) * $signed(s0_r));

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      n1_r <= (57'd1 << 56) - {sq[28:0], 28'd0};
      priority if (lkm0_r) begin
        sd1_r.zy <= {m21_r[15], m21_r};
        sd1_r.zx <= {m31_r[15], m31_r};
      end else if (lkp0_r) begin
        sd1_r.zy <= -{m21_r[15], m21_r};
        sd1_r.zx <= -{m31_r[15], m31_r};
      end else begin
        sd1_r.zy <= {m12_r[15], m12_r};
        sd1_r.zx <= {m11_r[15], m11_r};
      end
      sd1_r.m23 <= m23_r;
      sd1_r.m33 <= m33_r;
      sd1_r.s   <= s0_r;
      sd1_r.lkm <= lkm0_r;
      sd1_r.lkp <= lkp0_r && !lkm0_r;
    end
  end

  // Square-root stages with side data delayed alongside
  logic [28:0]    root;
  rme_pkg::side_t sd_r [SQ_ST];

  rme_isqrt u_isqrt (
    .clk    (clk),
    .en     (adv[SB +: SQ_ST]),
    .n_i    (n1_r),
    .root_o (root)
  );

  always_ff @(posedge clk) begin
    for (int s = 0; s < SQ_ST; s++) begin
      if (adv[SB+s]) sd_r[s] <= (s == 0) ? sd1_r : sd_r[(s == 0) ? 0 : s-1];
    end
  end

  // CORDIC units: x1, x2, z1 (or lock z), z2, asin
  rme_pkg::side_t sc;
  rme_pkg::cd_t   a_x1, a_x2, a_z1, a_z2, a_as;
  logic [1:0]     lk_r [CD_ST];

  assign sc = sd_r[SQ_ST-1];

  rme_cordic #(.STEPS(CORDIC_STEPS)) u_cx1 (
    .clk(clk), .en(adv[CB +: CD_ST]),
    .y_i(rme_pkg::to_q30({sc.m23[15], sc.m23})),
    .x_i(rme_pkg::to_q30({sc.m33[15], sc.m33})),
    .ang_o(a_x1)
  );

  rme_cordic #(.STEPS(CORDIC_STEPS)) u_cx2 (
    .clk(clk), .en(adv[CB +: CD_ST]),
    .y_i(rme_pkg::to_q30(-{sc.m23[15], sc.m23})),
    .x_i(rme_pkg::to_q30(-{sc.m33[15], sc.m33})),
    .ang_o(a_x2)
  );

  rme_cordic #(.STEPS(CORDIC_STEPS)) u_cz1 (
    .clk(clk), .en(adv[CB +: CD_ST]),
    .y_i(rme_pkg::to_q30(sc.zy)),
    .x_i(rme_pkg::to_q30(sc.zx)),
    .ang_o(a_z1)
  );

  rme_cordic #(.STEPS(CORDIC_STEPS)) u_cz2 (
    .clk(clk), .en(adv[CB +: CD_ST]),
    .y_i(rme_pkg::to_q30(-sc.zy)),
    .x_i(rme_pkg::to_q30(-sc.zx)),
    .ang_o(a_z2)
  );

  rme_cordic #(.STEPS(CORDIC_STEPS)) u_cas (
    .clk(clk), .en(adv[CB +: CD_ST]),
    .y_i(rme_pkg::to_q30({sc.s[15], sc.s})),
    .x_i({{(rme_pkg::CD_W-29){1'b0}}, root}),
    .ang_o(a_as)
  );

  always_ff @(posedge clk) begin
    for (int s = 0; s < CD_ST; s++) begin
      if (adv[CB+s]) lk_r[s] <= (s == 0) ? {sc.lkp, sc.lkm} : lk_r[(s == 0) ? 0 : s-1];
    end
  end

  // Rounding stage
  logic signed [15:0] x1_r, x2_r, y1_r, y2_r, z1_r, z2_r;
  logic [1:0]         lkq_r;

  always_ff @(posedge clk) begin
    if (adv[RI]) begin
      x1_r  <= rme_pkg::to_q12(a_x1);
      x2_r  <= rme_pkg::to_q12(a_x2);
      y1_r  <= rme_pkg::to_q12(-a_as);
      y2_r  <= rme_pkg::to_q12(rme_pkg::PI_Q30 + a_as);
      z1_r  <= rme_pkg::to_q12(a_z1);
      z2_r  <= rme_pkg::to_q12(a_z2);
      lkq_r <= lk_r[CD_ST-1];
    end
  end

  // Select stage and output register
  function automatic logic [16:0] abs16(input logic signed [15:0] v);
    return v[15] ? 17'(-{v[15], v}) : {1'b0, v};
  endfunction

  logic [18:0] sum1, sum2;
  assign sum1 = 19'(abs16(x1_r)) + 19'(abs16(y1_r)) + 19'(abs16(z1_r));
  assign sum2 = 19'(abs16(x2_r)) + 19'(abs16(y2_r)) + 19'(abs16(z2_r));

  logic signed [15:0] ox_r, oy_r, oz_r;
  rme_pkg::case_t     oc_r;

  always_ff @(posedge clk) begin
    if (adv[OI]) begin
      priority if (lkq_r[0]) begin
        ox_r <= '0;
        oy_r <= rme_pkg::to_q12(rme_pkg::HALF_PI_Q30);
        oz_r <= z1_r;
        oc_r <= rme_pkg::CASE_LOCK_M;
      end else if (lkq_r[1]) begin
        ox_r <= '0;
        oy_r <= rme_pkg::to_q12(-rme_pkg::HALF_PI_Q30);
        oz_r <= z1_r;
        oc_r <= rme_pkg::CASE_LOCK_P;
      end else if (sum1 <= sum2) begin
        ox_r <= x1_r;
        oy_r <= y1_r;
        oz_r <= z1_r;
        oc_r <= rme_pkg::CASE_GEN1;
      end else begin
        ox_r <= x2_r;
        oy_r <= y2_r;
        oz_r <= z2_r;
        oc_r <= rme_pkg::CASE_GEN2;
      end
    end
  end

  assign out_tvalid = v_r[NSTG-1];
  assign out_tdata  = {oz_r, oy_r, ox_r};
  assign out_tuser  = oc_r;

  // Assertions
  a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with an empty output stage");

  a_lock_x_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == rme_pkg::CASE_LOCK_M || out_tuser == rme_pkg::CASE_LOCK_P)
    |-> out_tdata[15:0] == 16'd0)
    else $error("gimbal lock item with nonzero angle_x");

  a_lock_m_y: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == rme_pkg::CASE_LOCK_M
    |-> out_tdata[31:16] == rme_pkg::to_q12(rme_pkg::HALF_PI_Q30))
    else $error("lock at minus one with wrong angle_y");

endmodule

// ----- bench/rotation_matrix_to_euler_tb.sv -----
// Testbench for rotation_matrix_to_euler: directed table plus random matrices,
// checked field by field against a bit-exact CORDIC predictor. Uses rme_pkg.
`timescale 1ns / 100ps

module rotation_matrix_to_euler_tb;

  localparam int STEPS     = 14;
  localparam int LATENCY   = 4 + 8 + (STEPS + 1) / 2;
  localparam int N_RANDOM  = 1830;
  localparam longint PI_V   = 64'sd3373259426;
  localparam longint HPI_V  = 64'sd1686629713;
  localparam longint ONE_V  = 64'sd16384;

  typedef struct {
    logic signed [15:0] m11, m12, m13, m21, m23, m31, m33;
  } matrix_t;

  typedef struct {
    logic signed [15:0] ax, ay, az;
    rme_pkg::case_t     sc;
  } euler_t;

  // directed row: matrix, optional typed-in result
  typedef struct {
    matrix_t m;
    bit      known;
    euler_t  e;
  } row_t;

  logic         clk;
  logic         rst_n;
  logic         cfg_we;
  logic [9:0]   cfg_wdata;
  logic         in_tvalid;
  logic         in_tready;
  logic [111:0] in_tdata;
  logic         out_tvalid;
  logic         out_tready;
  logic [47:0]  out_tdata;
  logic [1:0]   out_tuser;

  euler_t  angle_queue[$];
  int      n_errors;
  int      n_checked;
  int      n_locks;
  logic [9:0] tol_shadow;
  bit      no_idle;
  bit      hold_off;

  rotation_matrix_to_euler #(.CORDIC_STEPS(STEPS)) u_dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("FAILED: results differ");
    $finish;
  end

  // ---------------- predictor ----------------
  function automatic longint sra(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint atan_q30(int i);
    longint t[24] = '{64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6,
      64'h03FEAB76, 64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA,
      64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF,
      64'h0000FFFF, 64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF,
      64'h000007FF, 64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F};
    return t[i];
  endfunction

  // vectoring CORDIC, Q30 angle
  function automatic longint cordic_angle(longint y, longint x);
    longint ang, nx, ny;
    ang = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      ang = (y >= 0) ? PI_V : -PI_V;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < STEPS && i < 24; i++) begin
      if (y >= 0) begin
        nx = x + sra(y, i); ny = y - sra(x, i); ang += atan_q30(i);
      end else begin
        nx = x - sra(y, i); ny = y + sra(x, i); ang -= atan_q30(i);
      end
      x = nx;
      y = ny;
    end
    return ang;
  endfunction

  function automatic longint int_sqrt(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b; r = (r >> 1) + b;
      end else r >>= 1;
      b >>= 2;
    end
    return longint'(r);
  endfunction

  function automatic longint entry_angle(longint y, longint x);
    return cordic_angle(y * 16384, x * 16384);
  endfunction

  function automatic logic signed [15:0] round_q12(longint v);
    longint m, r;
    m = v < 0 ? -v : v;
    r = (m + (64'sd1 <<< 17)) >>> 18;
    if (v < 0) r = -r;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r[15:0];
  endfunction

  function automatic longint mag(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic euler_t predict_euler(matrix_t m, logic [9:0] tol);
    euler_t e;
    longint s, y1q, c, x1, y1, z1, x2, y2, z2;
    longint unsigned sq;
    s = m.m13;
    if (s > ONE_V) s = ONE_V;
    if (s < -ONE_V) s = -ONE_V;
    if (s + ONE_V < longint'(tol)) begin
      e.ax = '0; e.ay = round_q12(HPI_V);
      e.az = round_q12(entry_angle(m.m21, m.m31)); e.sc = rme_pkg::CASE_LOCK_M;
    end else if (ONE_V - s < longint'(tol)) begin
      e.ax = '0; e.ay = round_q12(-HPI_V);
      e.az = round_q12(entry_angle(-longint'(m.m21), -longint'(m.m31)));
      e.sc = rme_pkg::CASE_LOCK_P;
    end else begin
      sq = longint'(s * s) << 28;
      c = int_sqrt((64'd1 << 56) - sq);
      y1q = -cordic_angle(s * 16384, c);
      x1 = round_q12(entry_angle(m.m23, m.m33));
      y1 = round_q12(y1q);
      z1 = round_q12(entry_angle(m.m12, m.m11));
      x2 = round_q12(entry_angle(-longint'(m.m23), -longint'(m.m33)));
      y2 = round_q12(PI_V - y1q);
      z2 = round_q12(entry_angle(-longint'(m.m12), -longint'(m.m11)));
      if (mag(x1) + mag(y1) + mag(z1) <= mag(x2) + mag(y2) + mag(z2)) begin
        e.ax = 16'(x1); e.ay = 16'(y1); e.az = 16'(z1); e.sc = rme_pkg::CASE_GEN1;
      end else begin
        e.ax = 16'(x2); e.ay = 16'(y2); e.az = 16'(z2); e.sc = rme_pkg::CASE_GEN2;
      end
    end
    return e;
  endfunction

  // ---------------- stimulus helpers ----------------
  function automatic matrix_t mk(int a, int b, int c, int d, int e, int f, int g);
    matrix_t m;
    m.m11 = 16'(a); m.m12 = 16'(b); m.m13 = 16'(c); m.m21 = 16'(d);
    m.m23 = 16'(e); m.m31 = 16'(f); m.m33 = 16'(g);
    return m;
  endfunction

  // random matrix with m13 near the lock points now and then
  function automatic matrix_t random_matrix();
    matrix_t m;
    int sel;
    sel = $urandom_range(0, 99);
    m.m11 = 16'($urandom); m.m12 = 16'($urandom); m.m21 = 16'($urandom);
    m.m23 = 16'($urandom); m.m31 = 16'($urandom); m.m33 = 16'($urandom);
    if (sel < 20) m.m13 = 16'($urandom);
    else if (sel < 35) m.m13 = 16'(16384 - $urandom_range(0, 1100));
    else if (sel < 50) m.m13 = 16'(-16384 + $urandom_range(0, 1100));
    else if (sel < 55) m.m13 = $urandom_range(0, 1) ? 16'(16384 + $urandom_range(0, 16383))
                                                  : 16'(-16384 - $urandom_range(0, 16384));
    else m.m13 = 16'($signed($urandom_range(0, 32768)) - 16384);
    if (sel >= 70) begin
      // small operands exercise the near-zero CORDIC paths
      m.m11 = $signed(m.m11) >>> $urandom_range(0, 15);
      m.m12 = $signed(m.m12) >>> $urandom_range(0, 15);
      m.m23 = $signed(m.m23) >>> $urandom_range(0, 15);
      m.m33 = $signed(m.m33) >>> $urandom_range(0, 15);
    end
    return m;
  endfunction

  function automatic bit idle_now();
    return !no_idle && ($urandom_range(0, 99) < 22);
  endfunction

  task automatic send_matrix(matrix_t m);
    euler_t e;
    e = predict_euler(m, tol_shadow);
    in_tvalid <= 1'b1;
    in_tdata  <= {m.m33, m.m31, m.m23, m.m21, m.m13, m.m12, m.m11};
    angle_queue.push_back(e);
    if (e.sc == rme_pkg::CASE_LOCK_M || e.sc == rme_pkg::CASE_LOCK_P) n_locks++;
    do @(posedge clk); while (!in_tready);
    while (idle_now()) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (angle_queue.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic write_tolerance(logic [9:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    tol_shadow = v;
  endtask

  // ---------------- receiver and checker ----------------
  initial begin
    int hold;
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready) begin
        if (angle_queue.size() == 0) begin
          $display("%0t unexpected item: got %h/%0d", $time, out_tdata, out_tuser);
          n_errors++;
        end else begin
          euler_t e;
          e = angle_queue.pop_front();
          n_checked++;
          if (out_tdata[15:0] !== e.ax || out_tdata[31:16] !== e.ay ||
              out_tdata[47:32] !== e.az || out_tuser !== e.sc) begin
            $display({"%0t mismatch: expected x=%0d y=%0d z=%0d case=%0d,",
                      " got x=%0d y=%0d z=%0d case=%0d"},
                     $time, e.ax, e.ay, e.az, e.sc, $signed(out_tdata[15:0]),
                     $signed(out_tdata[31:16]), $signed(out_tdata[47:32]), out_tuser);
            n_errors++;
          end
        end
      end
      if (hold_off) begin
        out_tready <= 1'b0;
        for (hold = 0; hold < 3 * LATENCY; hold++) @(posedge clk);
        hold_off = 1'b0;
      end
      out_tready <= !idle_now();
    end
  end

  // ---------------- main sequence ----------------
  initial begin
    row_t rows[$];
    row_t r;
    logic [9:0] tols[5] = '{10'd1, 10'd0, 10'd1023, 10'd37, 10'd512};

    n_errors = 0; n_checked = 0; n_locks = 0;
    rst_n = 1'b0; cfg_we = 1'b0; cfg_wdata = '0;
    in_tvalid = 1'b0; in_tdata = '0;
    tol_shadow = 10'd1; no_idle = 1'b0; hold_off = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // identity, lock points, saturation, zero vectors and negative x axis
    r.known = 1; r.m = mk(16384, 0, 0, 0, 0, 0, 16384);
    r.e = '{16'sd0, 16'sd0, 16'sd0, rme_pkg::CASE_GEN1}; rows.push_back(r);
    r.m = mk(0, 0, -16384, 0, 0, 0, 0);
    r.e = '{16'sd0, 16'sd6434, 16'sd0, rme_pkg::CASE_LOCK_M}; rows.push_back(r);
    r.m = mk(0, 0, 16384, 0, 0, 0, 0);
    r.e = '{16'sd0, -16'sd6434, 16'sd0, rme_pkg::CASE_LOCK_P}; rows.push_back(r);
    r.m = mk(0, 0, -32768, 0, 0, 0, 0);
    r.e = '{16'sd0, 16'sd6434, 16'sd0, rme_pkg::CASE_LOCK_M}; rows.push_back(r);
    r.m = mk(0, 0, 32767, 0, 0, 0, 0);
    r.e = '{16'sd0, -16'sd6434, 16'sd0, rme_pkg::CASE_LOCK_P}; rows.push_back(r);
    r.known = 0;
    r.m = mk(0, 0, 0, 0, 0, 0, 0); rows.push_back(r);
    r.m = mk(-16384, 0, 0, 0, 0, 0, -16384); rows.push_back(r);
    r.m = mk(0, 0, -16384, 0, 0, -16384, 0); rows.push_back(r);
    r.m = mk(0, 0, 16384, 0, 0, 16384, 0); rows.push_back(r);
    r.m = mk(0, 0, -16383, 0, 0, 0, 0); rows.push_back(r);
    r.m = mk(0, 0, 16383, 0, 0, 0, 0); rows.push_back(r);
    r.m = mk(32767, 32767, 0, 32767, 32767, 32767, 32767); rows.push_back(r);
    r.m = mk(-32768, -32768, 0, -32768, -32768, -32768, -32768); rows.push_back(r);
    r.m = mk(-32768, 32767, 8192, 32767, -32768, 32767, -32768); rows.push_back(r);
    r.m = mk(0, 1, -8192, -1, 1, 1, 0); rows.push_back(r);
    r.m = mk(11585, -11585, 11585, 8192, -8192, -14189, 11585); rows.push_back(r);
    r.m = mk(-1, 0, 0, 0, 0, 0, -1); rows.push_back(r);

    foreach (rows[i]) begin
      euler_t got;
      if (rows[i].known) begin
        got = predict_euler(rows[i].m, tol_shadow);
        if (got.ax !== rows[i].e.ax || got.ay !== rows[i].e.ay ||
            got.az !== rows[i].e.az || got.sc !== rows[i].e.sc) begin
          $display("%0t table row %0d: expected case=%0d y=%0d, predictor case=%0d y=%0d",
                   $time, i, rows[i].e.sc, rows[i].e.ay, got.sc, got.ay);
          n_errors++;
        end
      end
      send_matrix(rows[i].m);
    end
    wait_drained();

    // random phases, one tolerance each
    foreach (tols[p]) begin
      write_tolerance(tols[p]);
      for (int n = 0; n < N_RANDOM / 5; n++) begin
        no_idle = (p == 2);
        if (p == 1 && n == 50) hold_off = 1'b1;
        send_matrix(random_matrix());
        // sender pause until the pipeline is empty
        if (p == 3 && n == 100) begin
          in_tvalid <= 1'b0;
          while (angle_queue.size() != 0) @(posedge clk);
        end
      end
      no_idle = 1'b0;
      wait_drained();
    end

    $display("Covered %0d matrices (%0d gimbal lock) in %0d phases: table plus five tolerances.",
             n_checked, n_locks, 6);
    if (n_errors == 0 && angle_queue.size() == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule
